[design/uks_pkg.sv]
// uks_pkg: shared types and constants for the unique key set block
// operation codes, result record, default table capacity
// no dependencies
package uks_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_READ_AT  = 2'd3
	} op_t;

	typedef struct packed {
		logic [COUNT_W-1:0]      entry_count;
		logic signed [KEY_W-1:0] read_key;
		logic                    ok;
	} res_t;

endpackage

[design/unique_key_set_with_compaction_top.sv]
// unique_key_set_with_compaction_top: insertion-ordered set of unique keys
// stream input and output channels around uks_core, with a result register
// depends on uks_pkg and uks_core
//
// - s_* channel carries one request per transaction: insert, remove,
//   contains or read-at, with the key and the read position
// - m_* channel returns exactly one result per request, in order: ok flag,
//   the key read (zero unless a read-at succeeded) and the entry count
// - the table is walked one entry per cycle through a single registered
//   memory read port and one key comparator; a search stops early on a
//   hit, a remove then shifts the entries above the match down, and an
//   insert into a full table or a read-at needs no walk
// - s_tready is high only while the sequencer is idle, from the cycle after
//   the result is loaded, so one request is handled at a time
// - a result waits in the output register while the receiver stalls; the
//   sequencer takes the next request meanwhile and holds its result until
//   the register is taken
// - reset empties the set; table contents need no clearing since only
//   entries below the count are ever read
module unique_key_set_with_compaction_top #(
	parameter int CAPACITY = uks_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // operation[1:0], key[33:2], position[39:34]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // ok[0], read_key[32:1], entry_count[39:33]
);

	logic          core_idle;
	logic          core_done;
	logic          slot_free;
	uks_pkg::res_t core_res;
	uks_pkg::res_t out_q;
	logic          out_valid_q;

	// result register may be refilled in the cycle it is taken
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = core_idle;

	uks_core #(
		.CAPACITY(CAPACITY)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && core_idle),
		.operation(uks_pkg::op_t'(s_tdata[1:0])),
		.key      (s_tdata[33:2]),
		.position (s_tdata[39:34]),
		.slot_free(slot_free),
		.idle     (core_idle),
		.done     (core_done),
		.res      (core_res)
	);

	// output register, control part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register, payload part
	always_ff @(posedge clk) begin
		if (core_done) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.entry_count, out_q.read_key, out_q.ok};

endmodule

[design/uks_core.sv]
// uks_core: key table memory, shared key comparator and operation sequencer
// walks the table one entry per cycle for search and shift-down delete
// depends on uks_pkg
module uks_core #(
	parameter int CAPACITY = uks_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  uks_pkg::op_t                  operation,
	input  logic signed [uks_pkg::KEY_W-1:0] key,
	input  logic [uks_pkg::POS_W-1:0]     position,
	input  logic                          slot_free,
	output logic                          idle,
	output logic                          done,
	output uks_pkg::res_t                 res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_FETCH  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	uks_pkg::op_t op_q;
	logic signed [uks_pkg::KEY_W-1:0] key_q;
	logic ok_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] rd_idx_s1;
	logic rd_valid_s1;
	logic [uks_pkg::KEY_W-1:0] rdata_s1;

	logic [uks_pkg::KEY_W-1:0] mem [CAPACITY];

	logic hit;
	logic more;
	logic pos_ok;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [uks_pkg::KEY_W-1:0] wr_data;
	logic [CW-1:0] idx_dec;
	logic [31:0] count_ext;

	// shared comparator on the entry just read
	assign hit     = rd_valid_s1 && (rdata_s1 == key_q);
	assign more    = rd_ptr_q < count_q;
	assign pos_ok  = 32'(position) < 32'(count_q);
	assign idx_dec = rd_idx_s1 - CW'(1);
	assign rd_addr = rd_ptr_q[AW-1:0];

	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = key_q;
		unique case (state_q)
			S_SEARCH: begin
				rd_en = more && !hit;
				if (!rd_valid_s1 && !more && op_q == uks_pkg::OP_INSERT) begin
					wr_en = 1'b1;
				end
			end
			S_SHIFT: begin
				rd_en = more;
				if (rd_valid_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_dec[AW-1:0];
					wr_data = rdata_s1;
				end
			end
			S_FETCH: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// key table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= uks_pkg::OP_INSERT;
			key_q       <= '0;
			ok_q        <= 1'b0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			rd_idx_s1   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_s1 <= rd_ptr_q;
				rd_ptr_q  <= CW'(rd_ptr_q + 1'b1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= operation;
						key_q    <= key;
						ok_q     <= 1'b0;
						rd_ptr_q <= '0;
						unique case (operation)
							uks_pkg::OP_INSERT: begin
								if (count_q >= CW'(CAPACITY)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							uks_pkg::OP_REMOVE, uks_pkg::OP_CONTAINS: begin
								state_q <= S_SEARCH;
							end
							uks_pkg::OP_READ_AT: begin
								if (pos_ok) begin
									rd_ptr_q <= CW'(position);
									ok_q     <= 1'b1;
									state_q  <= S_FETCH;
								end else begin
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						unique case (op_q)
							uks_pkg::OP_REMOVE: begin
								// restart the walk just above the match
								rd_ptr_q <= CW'(rd_idx_s1 + 1'b1);
								state_q  <= S_SHIFT;
							end
							uks_pkg::OP_CONTAINS: begin
								ok_q    <= 1'b1;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end else if (!rd_valid_s1 && !more) begin
						if (op_q == uks_pkg::OP_INSERT) begin
							count_q <= CW'(count_q + 1'b1);
							ok_q    <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (!rd_valid_s1 && !more) begin
						count_q <= CW'(count_q - 1'b1);
						ok_q    <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_FETCH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign count_ext       = 32'(count_q);
	assign idle            = (state_q == S_IDLE);
	assign done            = (state_q == S_DONE) && slot_free;
	assign res.ok          = ok_q;
	assign res.read_key    = (op_q == uks_pkg::OP_READ_AT && ok_q) ? rdata_s1 : '0;
	assign res.entry_count = count_ext[uks_pkg::COUNT_W-1:0];

endmodule
